### hw/rtl/ced_pkg.sv
// ----------------------------------------------------------------------------
// Closest-word edit distance package
// Shared widths, default parameter values, item kinds and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ced_pkg;

	localparam int MAX_LEN_DEF   = 32;
	localparam int MAX_WORDS_DEF = 4096;

	localparam int CHAR_W  = 8;
	localparam int DIST_W  = 6;
	localparam int INDEX_W = 12;

	localparam logic KIND_QUERY = 1'b0;
	localparam logic KIND_DICT  = 1'b1;

	localparam logic [DIST_W-1:0] BEST_NONE = '1;

	typedef enum logic {
		ST_IDLE,
		ST_CELL
	} ced_state_t;

endpackage

`default_nettype wire

### hw/rtl/closest_word_edit_distance_unit.sv
// ----------------------------------------------------------------------------
// Closest-word edit distance unit
// Streams a query word and then dictionary words, and reports the unit-cost
// Levenshtein distance of every dictionary word along with the best match.
// ----------------------------------------------------------------------------
// Usage: a transaction is accepted on a rising edge with start high and busy
// low; kind selects a query byte or a dictionary byte, last marks the final
// byte of a word. The first query byte after a dictionary byte, after a query
// byte with last set, or after reset begins a new search and clears the best
// match and the word index.
// A query byte is taken in its accept cycle and busy stays low. A dictionary
// byte is accepted and then a single shared cell walks the column, one row per
// cycle and one row per stored query byte, reading the query and the previous
// column from memory. No walk takes place with an empty query or once the
// word is past MAX_LEN bytes.
// When the dictionary byte carrying last is finished, done pulses for exactly
// one cycle, the cycle after the final row or after a walk-free accept, with
// the word's distance, index, best match so far and the truncation flag. The
// receiver cannot stall; the result is only held until the next word ends.
// Reset clears the control state; the query memory needs no clearing because
// no row past the loaded query length is ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_word_edit_distance_unit #(
	parameter int MAX_LEN   = ced_pkg::MAX_LEN_DEF,
	parameter int MAX_WORDS = ced_pkg::MAX_WORDS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           kind,
	input  wire logic [ced_pkg::CHAR_W-1:0]     char_code,
	input  wire logic                           last,
	output logic                                done,
	output logic      [ced_pkg::DIST_W-1:0]     distance,
	output logic      [ced_pkg::INDEX_W-1:0]    word_index,
	output logic                                is_best,
	output logic      [ced_pkg::DIST_W-1:0]     best_distance,
	output logic      [ced_pkg::INDEX_W-1:0]    best_index,
	output logic                                truncated
);

	localparam int ADDR_W = $clog2(MAX_LEN);
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int CNT_W  = $clog2(MAX_WORDS);
	localparam int WIDE_W = CNT_W + ced_pkg::INDEX_W;

	ced_pkg::ced_state_t state_q, state_d;

	// Search bookkeeping.
	logic [LEN_W-1:0]           qlen_q;
	logic                       open_q;
	logic [LEN_W-1:0]           dpos_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [ced_pkg::DIST_W-1:0] best_dist_q;
	logic [CNT_W-1:0]           best_idx_q;
	logic                       best_valid_q;
	logic                       ovf_q;
	logic                       wtrunc_q;

	// Column walk registers.
	logic [ced_pkg::CHAR_W-1:0] char_q;
	logic                       last_q;
	logic                       first_q;
	logic [LEN_W-1:0]           diag_q;
	logic [LEN_W-1:0]           left_q;
	logic [ADDR_W-1:0]          idx_q;
	logic [LEN_W-1:0]           corner_q;

	// Memory interface.
	logic                       q_we;
	logic [ADDR_W-1:0]          q_waddr;
	logic                       d_we;
	logic [ADDR_W-1:0]          raddr;
	logic [ced_pkg::CHAR_W-1:0] q_rdata;
	logic [LEN_W-1:0]           d_rdata;

	logic                       accept;
	logic                       q_acc;
	logic                       d_acc;
	logic                       drop;
	logic                       qlen_zero;
	logic [LEN_W-1:0]           row;
	logic                       last_row;
	logic [LEN_W-1:0]           cell_up;
	logic [LEN_W-1:0]           cell_value;
	logic                       emit;
	logic [LEN_W-1:0]           emit_dist;
	logic [ced_pkg::DIST_W-1:0] emit_dist6;
	logic                       better;
	logic [WIDE_W-1:0]          cnt_wide;
	logic [WIDE_W-1:0]          best_wide;

	assign busy      = (state_q != ced_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign q_acc     = accept && (kind == ced_pkg::KIND_QUERY);
	assign d_acc     = accept && (kind == ced_pkg::KIND_DICT);
	assign drop      = (dpos_q == LEN_W'(MAX_LEN));
	assign qlen_zero = (qlen_q == '0);

	// Row number of the cell being updated, 1-based.
	assign row      = LEN_W'(idx_q) + LEN_W'(1);
	assign last_row = (row == qlen_q);

	// On the first byte of a word the previous column is the identity 0..len,
	// so the memory is bypassed instead of reloaded.
	assign cell_up = first_q ? row : d_rdata;

	ced_store #(
		.MAX_LEN (MAX_LEN),
		.ADDR_W  (ADDR_W),
		.LEN_W   (LEN_W)
	) u_store (
		.clk     (clk),
		.q_we    (q_we),
		.q_waddr (q_waddr),
		.q_wdata (char_code),
		.d_we    (d_we),
		.d_waddr (idx_q),
		.d_wdata (cell_value),
		.raddr   (raddr),
		.q_rdata (q_rdata),
		.d_rdata (d_rdata)
	);

	ced_cell #(
		.LEN_W (LEN_W)
	) u_cell (
		.query_byte (q_rdata),
		.word_byte  (char_q),
		.diag       (diag_q),
		.up         (cell_up),
		.left       (left_q),
		.cell_value (cell_value)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ced_pkg::ST_IDLE: begin
				if (d_acc && !drop && !qlen_zero) begin
					state_d = ced_pkg::ST_CELL;
				end
			end
			ced_pkg::ST_CELL: begin
				if (last_row) begin
					state_d = ced_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ced_pkg::ST_IDLE;
			end
		endcase
	end

	// Memory controls and result selection.
	always_comb begin
		q_we      = q_acc && (!open_q || (qlen_q < LEN_W'(MAX_LEN)));
		q_waddr   = open_q ? ADDR_W'(qlen_q) : '0;
		d_we      = 1'b0;
		raddr     = '0;
		emit      = 1'b0;
		emit_dist = '0;
		unique case (state_q)
			ced_pkg::ST_IDLE: begin
				emit = d_acc && last && (drop || qlen_zero);
				priority if (drop) begin
					emit_dist = qlen_zero ? dpos_q : corner_q;
				end else begin
					emit_dist = dpos_q + LEN_W'(1);
				end
			end
			ced_pkg::ST_CELL: begin
				d_we      = 1'b1;
				raddr     = ADDR_W'(row);
				emit      = last_row && last_q;
				emit_dist = cell_value;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign emit_dist6 = ced_pkg::DIST_W'(emit_dist);
	assign better     = !best_valid_q || (emit_dist6 < best_dist_q);
	assign cnt_wide   = WIDE_W'(cnt_q);
	assign best_wide  = WIDE_W'(best_idx_q);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ced_pkg::ST_IDLE;
			qlen_q       <= '0;
			open_q       <= 1'b0;
			dpos_q       <= '0;
			cnt_q        <= '0;
			best_dist_q  <= ced_pkg::BEST_NONE;
			best_idx_q   <= '0;
			best_valid_q <= 1'b0;
			ovf_q        <= 1'b0;
			wtrunc_q     <= 1'b0;
			done         <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= emit;
			if (q_acc) begin
				if (!open_q) begin
					// A new search: the byte lands in row one.
					qlen_q       <= LEN_W'(1);
					dpos_q       <= '0;
					cnt_q        <= '0;
					best_dist_q  <= ced_pkg::BEST_NONE;
					best_idx_q   <= '0;
					best_valid_q <= 1'b0;
					ovf_q        <= 1'b0;
					wtrunc_q     <= 1'b0;
				end else if (qlen_q < LEN_W'(MAX_LEN)) begin
					qlen_q <= qlen_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				open_q <= !last;
			end
			if (d_acc) begin
				open_q <= 1'b0;
				// A word that ends right here is wrapped up by the result below.
				if (!emit) begin
					if (drop) begin
						wtrunc_q <= 1'b1;
					end else begin
						dpos_q <= dpos_q + LEN_W'(1);
					end
				end
			end
			if (emit) begin
				if (cnt_q != CNT_W'(MAX_WORDS - 1)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				dpos_q   <= '0;
				wtrunc_q <= 1'b0;
				if (better) begin
					best_valid_q <= 1'b1;
					best_dist_q  <= emit_dist6;
					best_idx_q   <= cnt_q;
				end
			end
		end
	end

	// Column walk and result payload.
	always_ff @(posedge clk) begin
		if (d_acc) begin
			char_q  <= char_code;
			last_q  <= last;
			first_q <= (dpos_q == '0);
			diag_q  <= dpos_q;
			left_q  <= dpos_q + LEN_W'(1);
			idx_q   <= '0;
		end else if (state_q == ced_pkg::ST_CELL) begin
			diag_q <= cell_up;
			left_q <= cell_value;
			idx_q  <= ADDR_W'(row);
			if (last_row) begin
				corner_q <= cell_value;
			end
		end
		if (emit) begin
			distance   <= emit_dist6;
			word_index <= cnt_wide[ced_pkg::INDEX_W-1:0];
			is_best    <= better;
			if (better) begin
				best_distance <= emit_dist6;
				best_index    <= cnt_wide[ced_pkg::INDEX_W-1:0];
			end else begin
				best_distance <= best_dist_q;
				best_index    <= best_wide[ced_pkg::INDEX_W-1:0];
			end
			truncated <= ovf_q || wtrunc_q || ((state_q == ced_pkg::ST_IDLE) && drop);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ced_cell.sv
// ----------------------------------------------------------------------------
// Edit distance cell
// One unit-cost Levenshtein update: copy the diagonal on a match, otherwise
// one more than the smallest of the three neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module ced_cell #(
	parameter int LEN_W = 6
) (
	input  wire logic [ced_pkg::CHAR_W-1:0] query_byte,
	input  wire logic [ced_pkg::CHAR_W-1:0] word_byte,
	input  wire logic [LEN_W-1:0]           diag,
	input  wire logic [LEN_W-1:0]           up,
	input  wire logic [LEN_W-1:0]           left,
	output logic      [LEN_W-1:0]           cell_value
);

	logic [LEN_W-1:0] min_ul;
	logic [LEN_W-1:0] min_all;

	always_comb begin
		min_ul  = (up < left) ? up : left;
		min_all = (min_ul < diag) ? min_ul : diag;
		if (query_byte == word_byte) begin
			cell_value = diag;
		end else begin
			cell_value = min_all + LEN_W'(1);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ced_store.sv
// ----------------------------------------------------------------------------
// Query and column storage
// Holds the query bytes and the edit distance column, rows 1 to MAX_LEN.
// Both memories share one read address and return registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ced_store #(
	parameter int MAX_LEN = ced_pkg::MAX_LEN_DEF,
	parameter int ADDR_W  = $clog2(MAX_LEN),
	parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          q_we,
	input  wire logic [ADDR_W-1:0]             q_waddr,
	input  wire logic [ced_pkg::CHAR_W-1:0]    q_wdata,
	input  wire logic                          d_we,
	input  wire logic [ADDR_W-1:0]             d_waddr,
	input  wire logic [LEN_W-1:0]              d_wdata,
	input  wire logic [ADDR_W-1:0]             raddr,
	output logic      [ced_pkg::CHAR_W-1:0]    q_rdata,
	output logic      [LEN_W-1:0]              d_rdata
);

	logic [ced_pkg::CHAR_W-1:0] query_mem [MAX_LEN];
	logic [LEN_W-1:0]           col_mem   [MAX_LEN];

	always_ff @(posedge clk) begin
		if (q_we) begin
			query_mem[q_waddr] <= q_wdata;
		end
		q_rdata <= query_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			col_mem[d_waddr] <= d_wdata;
		end
		d_rdata <= col_mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/ced_checker.sv
// ----------------------------------------------------------------------------
// Closest-word edit distance checker
// Port-level properties of the edit distance unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ced_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        kind,
	input wire logic                        done,
	input wire logic [ced_pkg::DIST_W-1:0]  distance,
	input wire logic [ced_pkg::INDEX_W-1:0] word_index,
	input wire logic                        is_best,
	input wire logic [ced_pkg::DIST_W-1:0]  best_distance,
	input wire logic [ced_pkg::INDEX_W-1:0] best_index
);

	// A new best match must be reported as the word itself.
	a_best_is_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_best |-> (best_distance == distance) && (best_index == word_index))
		else $error("new best match differs from the reported word");

	// A word that is not the new best can never beat the stored best.
	a_best_not_worse: assert property (@(posedge clk) disable iff (!arst_n)
		done && !is_best |-> (best_distance <= distance))
		else $error("best distance exceeds a word that was not taken");

	// A query transaction completes in its accept cycle and yields no result.
	a_query_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == ced_pkg::KIND_QUERY) |=> !done && !busy)
		else $error("query transaction produced a result or stalled");

	// Results only follow an accepted dictionary transaction or a busy walk.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || ($past(start) && ($past(kind) == ced_pkg::KIND_DICT)))
		else $error("result without a dictionary transaction");

endmodule

bind closest_word_edit_distance_unit ced_checker u_ced_checker (.*);

`default_nettype wire
